[design/ffra_pkg.sv]
// Package with shared types and codes for the first-fit range allocator.
package ffra_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_NOFIT = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [0:0]  cmd;
    logic [31:0] req_size;
    logic [31:0] blk_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_offset;
    logic [31:0] out_size;
    logic [31:0] free_bytes;
  } rsp_t;

endpackage

[design/ffra_req_if.sv]
// Valid/ready channel interface that carries allocator requests.
interface ffra_req_if;
  import ffra_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/ffra_rsp_if.sv]
// Valid/ready channel interface that carries allocator responses.
interface ffra_rsp_if;
  import ffra_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/ffra_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
module ffra_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[design/first_fit_range_allocator.sv]
// Top level of the first-fit range allocator with a segment table in RAM.
//
//   channel  dir  handshake    contents
//   req      in   valid/ready  cmd, req_size, blk_offset
//   rsp      out  valid/ready  status, out_offset, out_size, free_bytes
//   cfg      in   we only      range size in bytes
//
// A request scans the table entries one at a time and then moves entries on insert
// or remove, since the segment RAM has a single read port.
// Reset empties the table at once; no clearing pass is needed.
// A new request is taken while the last response still waits to be taken.
module first_fit_range_allocator #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  ffra_req_if.sink          req,
  ffra_rsp_if.source        rsp
);
  import ffra_pkg::*;

  localparam int IdxW = $clog2(MAX_SEGMENTS);
  localparam int CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int AW = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CHK, S_DECIDE, S_DN_RD, S_DN_WR, S_UP_RD, S_UP_WR, S_INS, S_OUT
  } state_e;

  state_e           state_q;
  logic [0:0]       cmd_q;
  logic [AW-1:0]    size_q, off_q, avail_q;
  logic [CntW-1:0]  cnt_q, idx_q, end_q, pidx_q;
  logic             eq_seen_q;
  logic             adjp_q;
  logic             has_next_q;
  logic [AW-1:0]    pstart_q, plen_q;
  logic [AW-1:0]    nstart_q, nlen_q;
  status_e          st_q;
  rsp_t             rsp_q;
  logic             rsp_v_q;

  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  logic [AW-1:0]    ws, wl, rs, rl;
  logic             busy;
  logic             adjn;
  logic [CntW-1:0]  idx_inc, idx_dec;

  ffra_ram #(.Width(AW), .Depth(MAX_SEGMENTS)) u_start (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(ws), .raddr_i(raddr), .rdata_o(rs)
  );
  ffra_ram #(.Width(AW), .Depth(MAX_SEGMENTS)) u_len (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wl), .raddr_i(raddr), .rdata_o(rl)
  );

  logic [AW-1:0] cfg_val;
  assign cfg_val = cfg_wdata_i[AW-1:0];

  assign idx_inc = idx_q + CntW'(1);
  assign idx_dec = idx_q - CntW'(1);
  assign adjn    = has_next_q && (({1'b0, off_q} + {1'b0, size_q}) == {1'b0, nstart_q});
  assign raddr   = idx_q[IdxW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = idx_q[IdxW-1:0];
    ws    = rs;
    wl    = rl;
    unique case (state_q)
      S_CHK: begin
        if (cmd_q == CMD_ALLOC && rl > size_q) begin
          we = 1'b1;
          ws = rs + size_q;
          wl = rl - size_q;
        end
      end
      S_DECIDE: begin
        if (adjp_q) begin
          we    = 1'b1;
          waddr = pidx_q[IdxW-1:0];
          ws    = pstart_q;
          wl    = adjn ? plen_q + size_q + nlen_q : plen_q + size_q;
        end else if (adjn) begin
          we = 1'b1;
          ws = off_q;
          wl = nlen_q + size_q;
        end else if (cnt_q != CntW'(MAX_SEGMENTS) && idx_q == cnt_q) begin
          we = 1'b1;
          ws = off_q;
          wl = size_q;
        end
      end
      S_DN_WR: begin
        we    = 1'b1;
        waddr = idx_dec[IdxW-1:0];
      end
      S_UP_WR: begin
        we    = 1'b1;
        waddr = idx_inc[IdxW-1:0];
      end
      S_INS: begin
        we    = 1'b1;
        waddr = end_q[IdxW-1:0];
        ws    = off_q;
        wl    = size_q;
      end
      default: begin
      end
    endcase
    if (cfg_we_i) begin
      we    = 1'b1;
      waddr = '0;
      ws    = '0;
      wl    = cfg_val;
    end
  end

  assign busy      = (state_q != S_IDLE);
  assign req.ready = !busy;
  assign rsp.valid = rsp_v_q;
  assign rsp.data  = rsp_q;

  logic [AW-1:0] req_sz, req_off;
  assign req_sz  = req.data.req_size[AW-1:0];
  assign req_off = req.data.blk_offset[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      avail_q <= '0;
      rsp_v_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && (!rsp_v_q || rsp.ready)) begin
        rsp_v_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_v_q <= 1'b0;
      end
      if (cfg_we_i) begin
        avail_q <= cfg_val;
        cnt_q   <= (cfg_val == '0) ? '0 : CntW'(1);
      end
      unique case (state_q)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q      <= req.data.cmd;
            size_q     <= req_sz;
            off_q      <= req_off;
            idx_q      <= '0;
            eq_seen_q  <= 1'b0;
            adjp_q     <= 1'b0;
            has_next_q <= 1'b0;
            if (req_sz == '0) begin
              st_q    <= ST_ZERO;
              state_q <= S_OUT;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx_q == cnt_q) begin
            if (cmd_q == CMD_ALLOC) begin
              st_q    <= ST_NOFIT;
              state_q <= S_OUT;
            end else begin
              state_q <= S_DECIDE;
            end
          end else begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (cmd_q == CMD_ALLOC) begin
            if (rl >= size_q) begin
              pstart_q <= rs;
              avail_q  <= avail_q - size_q;
              st_q     <= ST_OK;
              if (rl == size_q) begin
                end_q   <= cnt_q - CntW'(1);
                cnt_q   <= cnt_q - CntW'(1);
                idx_q   <= idx_inc;
                state_q <= S_DN_RD;
              end else begin
                state_q <= S_OUT;
              end
            end else begin
              idx_q   <= idx_inc;
              state_q <= S_SCAN;
            end
          end else begin
            if (!eq_seen_q && rs < off_q) begin
              pstart_q <= rs;
              plen_q   <= rl;
              pidx_q   <= idx_q;
              adjp_q   <= (({1'b0, rs} + {1'b0, rl}) == {1'b0, off_q});
              idx_q    <= idx_inc;
              state_q  <= S_SCAN;
            end else if (rs == off_q) begin
              eq_seen_q <= 1'b1;
              idx_q     <= idx_inc;
              state_q   <= S_SCAN;
            end else begin
              nstart_q   <= rs;
              nlen_q     <= rl;
              has_next_q <= 1'b1;
              state_q    <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (adjp_q || adjn) begin
            st_q    <= ST_OK;
            avail_q <= avail_q + size_q;
            if (adjp_q && adjn) begin
              end_q   <= cnt_q - CntW'(1);
              cnt_q   <= cnt_q - CntW'(1);
              idx_q   <= idx_inc;
              state_q <= S_DN_RD;
            end else begin
              state_q <= S_OUT;
            end
          end else if (cnt_q == CntW'(MAX_SEGMENTS)) begin
            st_q    <= ST_FULL;
            state_q <= S_OUT;
          end else begin
            st_q    <= ST_OK;
            avail_q <= avail_q + size_q;
            cnt_q   <= cnt_q + CntW'(1);
            if (idx_q == cnt_q) begin
              state_q <= S_OUT;
            end else begin
              end_q   <= idx_q;
              idx_q   <= cnt_q - CntW'(1);
              state_q <= S_UP_RD;
            end
          end
        end
        S_DN_RD: begin
          if (idx_q > end_q) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_DN_WR;
          end
        end
        S_DN_WR: begin
          idx_q   <= idx_inc;
          state_q <= S_DN_RD;
        end
        S_UP_RD: begin
          state_q <= S_UP_WR;
        end
        S_UP_WR: begin
          if (idx_q == end_q) begin
            state_q <= S_INS;
          end else begin
            idx_q   <= idx_dec;
            state_q <= S_UP_RD;
          end
        end
        S_INS: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_v_q || rsp.ready) begin
            rsp_q.status     <= st_q;
            rsp_q.out_offset <= (st_q == ST_OK && cmd_q == CMD_ALLOC)
                                ? 32'(pstart_q) : '0;
            rsp_q.out_size   <= (st_q == ST_OK) ? 32'(size_q) : '0;
            rsp_q.free_bytes <= 32'(avail_q);
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_SEGMENTS)) else $error("segment count overflow");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> state_q == S_IDLE) else $error("ready while busy");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_v_q && !rsp.ready |=> rsp_v_q) else $error("response dropped");
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_v_q && !rsp.ready |=> $stable(rsp.data)) else $error("response changed");
endmodule
